// ===== rtl/core/iafp_pkg.sv =====
`timescale 1ns / 1ps
package iafp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h53;
  localparam int unsigned DATA_BYTES = 9;
  localparam int unsigned STORE_DEPTH = 8;

  // Angle scaling: 180/256 of the raw word, wrapped by 360 degrees in 1/128 units.
  localparam logic [7:0]  ANGLE_MUL   = 8'd180;
  localparam logic [15:0] RAW_HALF    = 16'd32768;
  localparam logic [15:0] ANGLE_WRAP  = 16'd46080;

  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic        [15:0] version_word;
  } frame_res_t;

endpackage

// ===== rtl/core/iafp_angle_conv.sv =====
`timescale 1ns / 1ps
module iafp_angle_conv
  import iafp_pkg::*;
(
  input  logic        [15:0] raw,
  output logic signed [15:0] angle
);

  logic [23:0] prod;
  logic [15:0] scaled;

  assign prod   = raw * ANGLE_MUL;
  assign scaled = prod[23:8];

  // Words above half scale stand for negative angles.
  assign angle = (raw > RAW_HALF) ? signed'(scaled - ANGLE_WRAP) : signed'(scaled);

endmodule

// ===== rtl/core/iafp_parser.sv =====
`timescale 1ns / 1ps
module iafp_parser
  import iafp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output frame_res_t res
);

  localparam logic [1:0] PH_HDR1 = 2'd0;
  localparam logic [1:0] PH_HDR2 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic signed [15:0] roll_r, roll_nxt;
  logic signed [15:0] pitch_r, pitch_nxt;
  logic signed [15:0] yaw_r, yaw_nxt;
  logic [7:0] store_r [STORE_DEPTH];
  logic       store_we;

  logic signed [15:0] roll_cv, pitch_cv, yaw_cv;
  logic ok;

  iafp_angle_conv u_conv_roll  (.raw({store_r[1], store_r[0]}), .angle(roll_cv));
  iafp_angle_conv u_conv_pitch (.raw({store_r[3], store_r[2]}), .angle(pitch_cv));
  iafp_angle_conv u_conv_yaw   (.raw({store_r[5], store_r[4]}), .angle(yaw_cv));

  assign ok = (sum_r == rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    store_we  = 1'b0;
    res_valid = 1'b0;
    case (phase_r)
      PH_HDR2: begin
        if (rx_byte == HDR_SECOND) begin
          phase_nxt = PH_DATA;
          count_nxt = 4'd0;
          sum_nxt   = HDR_FIRST + HDR_SECOND;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
      PH_DATA: begin
        if (count_r < 4'(DATA_BYTES - 1)) begin
          store_we  = 1'b1;
          sum_nxt   = sum_r + rx_byte;
          count_nxt = count_r + 4'd1;
        end else begin
          res_valid = 1'b1;
          phase_nxt = PH_HDR1;
          count_nxt = 4'd0;
          if (ok) begin
            roll_nxt  = roll_cv;
            pitch_nxt = pitch_cv;
            yaw_nxt   = yaw_cv;
          end
        end
      end
      default: begin
        if (rx_byte == HDR_FIRST) begin
          phase_nxt = PH_HDR2;
        end
      end
    endcase
  end

  assign res.frame_ok     = ok;
  assign res.roll_angle   = roll_nxt;
  assign res.pitch_angle  = pitch_nxt;
  assign res.yaw_angle    = yaw_nxt;
  assign res.version_word = {store_r[7], store_r[6]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      count_r <= 4'd0;
      sum_r   <= 8'd0;
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && store_we) begin
      store_r[count_r[2:0]] <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/imu_angle_frame_parser.sv =====
`timescale 1ns / 1ps
// A checksum beat passes through the input register and then the result register.
// Throughput: one beat per cycle; the input register and the parser step move
// together, gated only by the result register being free or being taken.
// Reset: synchronous, active low; clears the hunt state, the byte sum, the held
// angles and both valid flags. The frame byte store is not reset.
module imu_angle_frame_parser
  import iafp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [7:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_ok,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic        [15:0] out_version_word
);

  // Input register: one received beat waiting for the parser.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Result register.
  logic       out_valid_r;
  frame_res_t out_res_r;

  logic       out_free;
  logic       s1_adv;
  logic       in_take;
  logic       res_valid;
  frame_res_t res;

  // The parser may step whenever the result register can take a new beat.
  // This lets a new beat enter in the same cycle that an earlier result is taken.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  iafp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (s1_adv),
    .rx_byte  (s1_byte_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // A result beat is loaded only when the checksum byte is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ok     = out_res_r.frame_ok;
  assign out_roll_angle   = out_res_r.roll_angle;
  assign out_pitch_angle  = out_res_r.pitch_angle;
  assign out_yaw_angle    = out_res_r.yaw_angle;
  assign out_version_word = out_res_r.version_word;

endmodule
